>>> rtl/ckb_pkg.sv
// Shared types, constants and lookup tables for the color-key sprite blitter.
// Used by ckb_front, ckb_queue, ckb_back and color_key_sprite_blit.
package ckb_pkg;

    // Framebuffer geometry widths.
    localparam int DIM_BITS   = 10;
    localparam int ADDR_W     = 2 * DIM_BITS;
    localparam int CNT_W      = 20;
    localparam int DIM_LIM_W  = DIM_BITS + 1;
    localparam int PIXEL_W    = 8;
    localparam int TYPE_W     = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Number of sprite types with a transparent color.
    localparam int TYPE_COUNT = 9;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Register reset values.
    localparam logic [DIM_LIM_W-1:0] STRIDE_RESET = DIM_LIM_W'(320);
    localparam logic [DIM_LIM_W-1:0] ROWS_RESET   = DIM_LIM_W'(200);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPRITE_TYPE   = 3'd0,
        REG_REMAP_MODE    = 3'd1,
        REG_SOURCE_WIDTH  = 3'd2,
        REG_SOURCE_HEIGHT = 3'd3,
        REG_ORIGIN_X      = 3'd4,
        REG_ORIGIN_Y      = 3'd5,
        REG_LINE_STRIDE   = 3'd6,
        REG_FRAME_ROWS    = 3'd7
    } reg_idx_t;

    // Palette remap modes; the unused code behaves as the far palette.
    typedef enum logic [MODE_W-1:0] {
        REMAP_NONE = 2'd0,
        REMAP_NEAR = 2'd1,
        REMAP_FAR  = 2'd2
    } remap_mode_t;

    // Input item kinds.
    typedef enum logic {
        ACT_START = 1'b0,
        ACT_PIXEL = 1'b1
    } action_t;

    // Current configuration register contents.
    typedef struct packed {
        logic [TYPE_W-1:0]    sprite_type;
        logic [MODE_W-1:0]    remap_mode;
        logic [DIM_BITS-1:0]  source_width;
        logic [DIM_BITS-1:0]  source_height;
        logic [DIM_BITS-1:0]  origin_x;
        logic [DIM_BITS-1:0]  origin_y;
        logic [DIM_LIM_W-1:0] line_stride;
        logic [DIM_LIM_W-1:0] frame_rows;
    } cfg_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   row_base;
        logic [DIM_BITS-1:0] column;
        logic [PIXEL_W-1:0]  pixel;
        logic                done;
        logic [CNT_W-1:0]    drawn;
        logic                rejected;
    } cmd_t;

    // Transparent color of each sprite type.
    function automatic logic [PIXEL_W-1:0] key_color(input logic [TYPE_W-1:0] kind);
        logic [PIXEL_W-1:0] c;
        case (kind)
            4'd0:    c = 8'd13;
            4'd1:    c = 8'd11;
            4'd2:    c = 8'd11;
            4'd3:    c = 8'd4;
            4'd4:    c = 8'd4;
            4'd5:    c = 8'd4;
            4'd6:    c = 8'd13;
            4'd7:    c = 8'd4;
            4'd8:    c = 8'd4;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // Near palette, 16 entries.
    function automatic logic [PIXEL_W-1:0] near_pal(input logic [3:0] idx);
        logic [PIXEL_W-1:0] c;
        case (idx)
            4'd0:    c = 8'd0;
            4'd1:    c = 8'd1;
            4'd2:    c = 8'd2;
            4'd3:    c = 8'd3;
            4'd4:    c = 8'd4;
            4'd5:    c = 8'd3;
            4'd6:    c = 8'd6;
            4'd7:    c = 8'd7;
            4'd8:    c = 8'd5;
            4'd9:    c = 8'd0;
            4'd10:   c = 8'd0;
            4'd11:   c = 8'd11;
            4'd12:   c = 8'd12;
            4'd13:   c = 8'd13;
            4'd14:   c = 8'd14;
            default: c = 8'd15;
        endcase
        return c;
    endfunction

    // Far palette, 16 entries.
    function automatic logic [PIXEL_W-1:0] far_pal(input logic [3:0] idx);
        logic [PIXEL_W-1:0] c;
        case (idx)
            4'd0:    c = 8'd0;
            4'd1:    c = 8'd12;
            4'd2:    c = 8'd1;
            4'd3:    c = 8'd3;
            4'd4:    c = 8'd4;
            4'd5:    c = 8'd3;
            4'd6:    c = 8'd0;
            4'd7:    c = 8'd6;
            4'd8:    c = 8'd3;
            4'd9:    c = 8'd0;
            4'd10:   c = 8'd0;
            4'd11:   c = 8'd11;
            4'd12:   c = 8'd0;
            4'd13:   c = 8'd2;
            4'd14:   c = 8'd0;
            default: c = 8'd13;
        endcase
        return c;
    endfunction

    // Applies the selected palette to colors below 16.
    function automatic logic [PIXEL_W-1:0] remap_pixel(input logic [PIXEL_W-1:0] pix,
                                                       input logic [MODE_W-1:0]  mode);
        logic [PIXEL_W-1:0] c;
        c = pix;
        if (pix[PIXEL_W-1:4] == '0) begin
            if (mode == REMAP_NEAR) begin
                c = near_pal(pix[3:0]);
            end else if (mode != REMAP_NONE) begin
                c = far_pal(pix[3:0]);
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/ckb_front.sv
// Front part of the blitter: accepts items, validates sprites, tracks the
// raster position and draw count, and emits one classified command per item.
// Depends on ckb_pkg.
module ckb_front
    import ckb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [PIXEL_W-1:0]  s_pixel_in,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cmd_t                cmd
);

    logic [DIM_BITS-1:0] column_reg, column_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [CNT_W-1:0]    drawn_reg, drawn_next;
    logic [ADDR_W-1:0]   row_base_reg, row_base_next;
    logic                valid_reg, valid_next;

    logic                accept;
    logic                type_ok;
    logic                fit_ok;
    logic [2*DIM_LIM_W-2:0] start_base;
    logic                active;
    logic                skip;
    logic                row_end;
    logic                last_row;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;

    // Start checks: known type and the sprite fits the framebuffer.
    assign type_ok = cfg.sprite_type < TYPE_W'(TYPE_COUNT);
    assign fit_ok  = ({1'b0, cfg.origin_x} + {1'b0, cfg.source_width} <= cfg.line_stride) &&
                     ({1'b0, cfg.origin_y} + {1'b0, cfg.source_height} <= cfg.frame_rows);
    assign start_base = {{DIM_LIM_W{1'b0}}, cfg.origin_y} *
                        {{DIM_BITS{1'b0}}, cfg.line_stride};

    // Pixel classification against the current raster position.
    assign active   = valid_reg && (row_reg < cfg.source_height) && (cfg.source_width != '0);
    assign skip     = type_ok && (s_pixel_in == key_color(cfg.sprite_type));
    assign row_end  = ({1'b0, column_reg} + 1'b1) >= {1'b0, cfg.source_width};
    assign last_row = ({1'b0, row_reg} + 1'b1) >= {1'b0, cfg.source_height};

    // Next state and command for the item on the input.
    always_comb begin
        column_next   = column_reg;
        row_next      = row_reg;
        drawn_next    = drawn_reg;
        row_base_next = row_base_reg;
        valid_next    = valid_reg;

        cmd.we       = 1'b0;
        cmd.row_base = row_base_reg;
        cmd.column   = column_reg;
        cmd.pixel    = s_pixel_in;
        cmd.done     = 1'b0;
        cmd.drawn    = drawn_reg;
        cmd.rejected = !valid_reg;

        if (s_action == ACT_START) begin
            valid_next    = type_ok && fit_ok;
            column_next   = '0;
            row_next      = '0;
            drawn_next    = '0;
            row_base_next = start_base[ADDR_W-1:0];
            cmd.drawn     = '0;
            cmd.rejected  = !(type_ok && fit_ok);
        end else if (active) begin
            if (!skip) begin
                drawn_next = drawn_reg + 1'b1;
            end
            if (row_end) begin
                column_next   = '0;
                row_next      = row_reg + 1'b1;
                row_base_next = row_base_reg + ADDR_W'(cfg.line_stride);
            end else begin
                column_next   = column_reg + 1'b1;
            end
            cmd.we       = !skip;
            cmd.done     = row_end && last_row;
            cmd.drawn    = drawn_next;
            cmd.rejected = 1'b0;
        end
    end

    // Raster state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= '0;
            row_reg      <= '0;
            drawn_reg    <= '0;
            row_base_reg <= '0;
            valid_reg    <= 1'b0;
        end else if (accept) begin
            column_reg   <= column_next;
            row_reg      <= row_next;
            drawn_reg    <= drawn_next;
            row_base_reg <= row_base_next;
            valid_reg    <= valid_next;
        end
    end

endmodule

>>> rtl/ckb_queue.sv
// Small register queue of commands between the front and the back.
// Depends on ckb_pkg.
module ckb_queue
    import ckb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);

    cmd_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != QCNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer wrap and occupancy.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/ckb_back.sv
// Back part of the blitter: forms the write address, applies the palette and
// holds each result item in the output register until it is taken.
// Depends on ckb_pkg.
module ckb_back
    import ckb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cmd_t                cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_write_enable,
    output logic [ADDR_W-1:0]   m_write_address,
    output logic [PIXEL_W-1:0]  m_write_value,
    output logic                m_image_done,
    output logic [CNT_W-1:0]    m_drawn_count,
    output logic                m_rejected
);

    logic               valid_reg;
    logic               we_reg;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [PIXEL_W-1:0] value_reg, value_next;
    logic               done_reg;
    logic [CNT_W-1:0]   drawn_reg;
    logic               rejected_reg;
    logic               load;

    // The output register takes a new item when empty or being drained.
    assign cmd_ready = !valid_reg || m_ready;
    assign load      = cmd_valid && cmd_ready;

    // Address and color; both read zero when nothing is written.
    always_comb begin
        addr_next  = '0;
        value_next = '0;
        if (cmd.we) begin
            addr_next  = cmd.row_base + ADDR_W'(cfg.origin_x) + ADDR_W'(cmd.column);
            value_next = remap_pixel(cmd.pixel, cfg.remap_mode);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd_ready) begin
            valid_reg <= cmd_valid;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            we_reg       <= cmd.we;
            addr_reg     <= addr_next;
            value_reg    <= value_next;
            done_reg     <= cmd.done;
            drawn_reg    <= cmd.drawn;
            rejected_reg <= cmd.rejected;
        end
    end

    assign m_valid         = valid_reg;
    assign m_write_enable  = we_reg;
    assign m_write_address = addr_reg;
    assign m_write_value   = value_reg;
    assign m_image_done    = done_reg;
    assign m_drawn_count   = drawn_reg;
    assign m_rejected      = rejected_reg;

endmodule

>>> rtl/color_key_sprite_blit.sv
// Color-key sprite blitter: top level with configuration registers, front,
// command queue and back. Depends on ckb_pkg, ckb_front, ckb_queue, ckb_back.
//
// Usage: configure through the cfg channel (cfg_index picks the register,
// cfg_data carries the value, low bits used) while no item is in flight.
// On the s_ channel, action 0 starts a sprite and checks its type and fit;
// action 1 carries one source pixel in raster order. Each item gives exactly
// one result item on the m_ channel: a framebuffer write command with the
// address, color, last-pixel flag, running drawn count and rejected flag.
// A result passes through the command queue and the output register once
// its item is accepted. One item is taken per cycle while the receiver keeps
// taking results; the pixel-to-pixel raster update in the front loops through
// its own registers. A stalled receiver holds the output register; the queue
// (two entries by default) then fills and s_ready drops until output drains.
// Reset (aresetn low, synchronous) empties the queue and output, clears the
// raster state, marks the sprite rejected and loads register defaults
// (stride 320, 200 rows, others 0). cfg_ready is always high.
module color_key_sprite_blit
    import ckb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [PIXEL_W-1:0]    s_pixel_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_write_enable,
    output logic [ADDR_W-1:0]     m_write_address,
    output logic [PIXEL_W-1:0]    m_write_value,
    output logic                  m_image_done,
    output logic [CNT_W-1:0]      m_drawn_count,
    output logic                  m_rejected
);

    cfg_t cfg_reg;
    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sprite_type   <= '0;
            cfg_reg.remap_mode    <= REMAP_NONE;
            cfg_reg.source_width  <= '0;
            cfg_reg.source_height <= '0;
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.line_stride   <= STRIDE_RESET;
            cfg_reg.frame_rows    <= ROWS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_SPRITE_TYPE:   cfg_reg.sprite_type   <= cfg_data[TYPE_W-1:0];
                REG_REMAP_MODE:    cfg_reg.remap_mode    <= cfg_data[MODE_W-1:0];
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_data[DIM_BITS-1:0];
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_data[DIM_BITS-1:0];
                REG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data[DIM_BITS-1:0];
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_data[DIM_BITS-1:0];
                REG_LINE_STRIDE:   cfg_reg.line_stride   <= cfg_data[DIM_LIM_W-1:0];
                REG_FRAME_ROWS:    cfg_reg.frame_rows    <= cfg_data[DIM_LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: accept and classify.
    ckb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_pixel_in (s_pixel_in),
        .cmd_valid  (fq_valid),
        .cmd_ready  (fq_ready),
        .cmd        (fq_cmd)
    );

    // Queue between front and back.
    ckb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_cmd)
    );

    // Back: address, palette and output register.
    ckb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .cmd_valid       (qb_valid),
        .cmd_ready       (qb_ready),
        .cmd             (qb_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_enable  (m_write_enable),
        .m_write_address (m_write_address),
        .m_write_value   (m_write_value),
        .m_image_done    (m_image_done),
        .m_drawn_count   (m_drawn_count),
        .m_rejected      (m_rejected)
    );

`ifndef SYNTHESIS
    // A skipped or ignored pixel carries neither address nor color.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_write_address == '0 && m_write_value == '0)
        else $error("idle write command carries address or value");

    // A rejected item never writes and never ends a sprite.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> !m_write_enable && !m_image_done)
        else $error("rejected item writes or ends a sprite");

    // Reset leaves no result on the output.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result present right after reset");
`endif

endmodule
